// ===== design/qvr_pkg.sv =====
// Shared constants for the quaternion vector rotation pipeline.
// Holds component codes and the product/sign tables of both Hamilton products.
// No dependencies.
package qvr_pkg;

  typedef logic [1:0] comp_idx_t;

  localparam comp_idx_t CX = 2'd0;
  localparam comp_idx_t CY = 2'd1;
  localparam comp_idx_t CZ = 2'd2;
  localparam comp_idx_t CW = 2'd3;

  localparam int NUM_P1 = 12;  // q * (v,0): four sums of three products
  localparam int NUM_P2 = 12;  // t * conj(q): three sums of four products

  // t = q * (v,0); row j (x,y,z,w) uses entries 3j..3j+2
  localparam comp_idx_t P1_Q [NUM_P1] = '{CY, CZ, CW,  CZ, CX, CW,  CX, CY, CW,  CX, CY, CZ};
  localparam comp_idx_t P1_V [NUM_P1] = '{CZ, CY, CX,  CX, CZ, CY,  CY, CX, CZ,  CX, CY, CZ};
  localparam logic      P1_NEG [NUM_P1] = '{1'b0, 1'b1, 1'b0,  1'b0, 1'b1, 1'b0,
                                            1'b0, 1'b1, 1'b0,  1'b1, 1'b1, 1'b1};

  // r = t * conj(q); row j (x,y,z) uses entries 4j..4j+3
  localparam comp_idx_t P2_T [NUM_P2] = '{CX, CY, CZ, CW,  CX, CY, CZ, CW,  CX, CY, CZ, CW};
  localparam comp_idx_t P2_Q [NUM_P2] = '{CW, CZ, CY, CX,  CZ, CW, CX, CY,  CY, CX, CW, CZ};
  localparam logic      P2_NEG [NUM_P2] = '{1'b0, 1'b1, 1'b0, 1'b1,  1'b0, 1'b0, 1'b1, 1'b1,
                                            1'b1, 1'b0, 1'b0, 1'b1};

endpackage

// ===== design/qvr_if.sv =====
// Valid/ready channel interfaces for the quaternion vector rotation block.
// qvr_in_if carries quaternion and vector, qvr_out_if the rotated vector.
// No dependencies.
interface qvr_in_if #(
  parameter int DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] quat_x;
  logic signed [DATA_WIDTH-1:0] quat_y;
  logic signed [DATA_WIDTH-1:0] quat_z;
  logic signed [DATA_WIDTH-1:0] quat_w;
  logic signed [DATA_WIDTH-1:0] vec_x;
  logic signed [DATA_WIDTH-1:0] vec_y;
  logic signed [DATA_WIDTH-1:0] vec_z;

  modport source (output valid, quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z,
                  input ready);
  modport sink (input valid, quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z,
                output ready);
endinterface

interface qvr_out_if #(
  parameter int DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] rot_x;
  logic signed [DATA_WIDTH-1:0] rot_y;
  logic signed [DATA_WIDTH-1:0] rot_z;
  logic                         saturated;

  modport source (output valid, rot_x, rot_y, rot_z, saturated, input ready);
  modport sink (input valid, rot_x, rot_y, rot_z, saturated, output ready);
endinterface

// ===== design/quaternion_vector_rotate_top.sv =====
// Quaternion vector rotation r = q * (v,0) * conj(q), fixed point, six register stages.
// Throughput 1 transaction per cycle while out.ready is high; out.valid is vld[6].
// Each stage holds its item until the next stage frees up; ready ripples back from out.ready.
// Reset clears the stage valid bits only; payload registers are not reset.
// Depends on qvr_pkg and the channel interfaces in qvr_if.sv.
module quaternion_vector_rotate_top import qvr_pkg::*; #(
  parameter int FRAC_BITS  = 14,
  parameter int DATA_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  qvr_in_if.sink     in,
  qvr_out_if.source  out
);

  localparam int DW = DATA_WIDTH;
  localparam int FB = FRAC_BITS;
  // first sum: exact width, at least FB+2, capped at 64 (wraps like a 64-bit word)
  localparam int S1_FULL = (2*DW + 2 > FB + 2) ? 2*DW + 2 : FB + 2;
  localparam int S1W     = (S1_FULL > 64) ? 64 : S1_FULL;
  localparam int TW      = S1W - FB;
  localparam int LOW     = TW / 2;
  localparam int HIW     = TW - LOW;
  localparam int PLW     = LOW + 1 + DW;
  localparam int PHW     = HIW + DW;
  localparam int PW      = TW + DW;
  localparam int S2_FULL = (TW + DW + 2 > FB + DW + 1) ? TW + DW + 2 : FB + DW + 1;
  localparam int S2W     = (S2_FULL > 64) ? 64 : S2_FULL;
  localparam int RW      = S2W - FB;

  localparam logic signed [S1W-1:0] HALF1 =
    {{(S1W-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};
  localparam logic signed [S2W-1:0] HALF2 =
    {{(S2W-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};
  localparam logic signed [DW-1:0] OUT_HI = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] OUT_LO = {1'b1, {(DW-1){1'b0}}};

  // stage control
  logic [6:1] vld;
  logic [7:1] en;

  always_comb begin
    en[7] = out.ready;
    for (int k = 6; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) vld[1] <= in.valid;
      for (int k = 2; k <= 6; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // stage 1: products of q and v
  logic signed [DW-1:0]   qin [4];
  logic signed [DW-1:0]   vin [3];
  logic signed [2*DW-1:0] p1_next [NUM_P1];
  logic signed [2*DW-1:0] p1 [NUM_P1];
  logic signed [DW-1:0]   q1 [4];

  assign qin[CX] = in.quat_x;
  assign qin[CY] = in.quat_y;
  assign qin[CZ] = in.quat_z;
  assign qin[CW] = in.quat_w;
  assign vin[CX] = in.vec_x;
  assign vin[CY] = in.vec_y;
  assign vin[CZ] = in.vec_z;

  always_comb begin
    for (int i = 0; i < NUM_P1; i++) begin
      p1_next[i] = (2*DW)'(qin[P1_Q[i]]) * (2*DW)'(vin[P1_V[i]]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      p1 <= p1_next;
      q1 <= qin;
    end
  end

  // stage 2: sum, round half up, shift -> t
  logic signed [TW-1:0] t2_next [4];
  logic signed [TW-1:0] t2 [4];
  logic signed [DW-1:0] q2 [4];

  always_comb begin
    logic signed [S1W-1:0] acc;
    logic signed [S1W-1:0] term;
    logic signed [S1W-1:0] shifted;
    for (int j = 0; j < 4; j++) begin
      acc = '0;
      for (int i = 0; i < 3; i++) begin
        term = S1W'(p1[3*j+i]);
        acc  = P1_NEG[3*j+i] ? acc - term : acc + term;
      end
      shifted    = (acc + HALF1) >>> FB;
      t2_next[j] = shifted[TW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      t2 <= t2_next;
      q2 <= q1;
    end
  end

  // stage 3: t * q as two partial products (low half unsigned, high half signed)
  logic signed [PLW-1:0] pp_lo_next [NUM_P2];
  logic signed [PHW-1:0] pp_hi_next [NUM_P2];
  logic signed [PLW-1:0] pp_lo [NUM_P2];
  logic signed [PHW-1:0] pp_hi [NUM_P2];

  always_comb begin
    for (int i = 0; i < NUM_P2; i++) begin
      pp_lo_next[i] = PLW'($signed({1'b0, t2[P2_T[i]][LOW-1:0]})) * PLW'(q2[P2_Q[i]]);
      pp_hi_next[i] = PHW'($signed(t2[P2_T[i]][TW-1:LOW])) * PHW'(q2[P2_Q[i]]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      pp_lo <= pp_lo_next;
      pp_hi <= pp_hi_next;
    end
  end

  // stage 4: merge partial products
  logic signed [S2W-1:0] prod_next [NUM_P2];
  logic signed [S2W-1:0] prod [NUM_P2];

  always_comb begin
    for (int i = 0; i < NUM_P2; i++) begin
      prod_next[i] = S2W'((PW'(pp_hi[i]) <<< LOW) + PW'(pp_lo[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) prod <= prod_next;
  end

  // stage 5: sum, round half up, shift -> r
  logic signed [RW-1:0] r5_next [3];
  logic signed [RW-1:0] r5 [3];

  always_comb begin
    logic signed [S2W-1:0] acc;
    logic signed [S2W-1:0] shifted;
    for (int j = 0; j < 3; j++) begin
      acc = '0;
      for (int i = 0; i < 4; i++) begin
        acc = P2_NEG[4*j+i] ? acc - prod[4*j+i] : acc + prod[4*j+i];
      end
      shifted    = (acc + HALF2) >>> FB;
      r5_next[j] = shifted[RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) r5 <= r5_next;
  end

  // stage 6: clip to output range, flag any clip
  logic signed [DW-1:0] rot_next [3];
  logic signed [DW-1:0] rot [3];
  logic [2:0]           clip_hi;
  logic [2:0]           clip_lo;
  logic                 sat_next;
  logic                 sat;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      clip_hi[j] = !r5[j][RW-1] && (|r5[j][RW-2:DW-1]);
      clip_lo[j] = r5[j][RW-1] && !(&r5[j][RW-2:DW-1]);
      priority if (clip_hi[j]) begin
        rot_next[j] = OUT_HI;
      end else if (clip_lo[j]) begin
        rot_next[j] = OUT_LO;
      end else begin
        rot_next[j] = r5[j][DW-1:0];
      end
    end
    sat_next = |(clip_hi | clip_lo);
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      rot <= rot_next;
      sat <= sat_next;
    end
  end

  assign in.ready      = en[1];
  assign out.valid     = vld[6];
  assign out.rot_x     = rot[CX];
  assign out.rot_y     = rot[CY];
  assign out.rot_z     = rot[CZ];
  assign out.saturated = sat;

  // assertions
  a_accept_fills_stage1: assert property (@(posedge clk) disable iff (rst)
    in.valid && in.ready |=> vld[1])
    else $error("accepted transaction did not reach stage 1");

  a_stall_means_full: assert property (@(posedge clk) disable iff (rst)
    !in.ready |-> (&vld))
    else $error("input stalled while a pipeline stage is empty");

  a_held_item_kept: assert property (@(posedge clk) disable iff (rst)
    vld[2] && !en[3] |=> vld[2] && $stable(t2[CX]) && $stable(t2[CW]))
    else $error("stage 2 dropped or changed a held item");

  a_sat_at_bound: assert property (@(posedge clk) disable iff (rst)
    out.valid && out.saturated |->
      (out.rot_x == OUT_HI) || (out.rot_x == OUT_LO) ||
      (out.rot_y == OUT_HI) || (out.rot_y == OUT_LO) ||
      (out.rot_z == OUT_HI) || (out.rot_z == OUT_LO))
    else $error("saturated flag set with no component at a bound");

endmodule
